[hdl/weighted_multiset_distance_similarity_unit_assert.svh]
// Assertion macros for the weighted multiset similarity unit.
// Included by the top-level RTL file, which carries the concurrent assertions.
`ifndef WEIGHTED_MULTISET_DISTANCE_SIMILARITY_UNIT_ASSERT_SVH
`define WEIGHTED_MULTISET_DISTANCE_SIMILARITY_UNIT_ASSERT_SVH

// implication checked at every clock edge outside reset
`define WMDS_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define WMDS_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[hdl/wmds_pkg.sv]
// Package for the weighted multiset similarity unit: widths, states, helpers.
// No dependencies.
`default_nettype none
package wmds_pkg;
   localparam int LABEL_W = 32;
   localparam int DEPTH_W = 16;
   localparam int SIM_W   = 17;
   localparam int SHARE_W = 13;
   localparam int SUM_W   = 48;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_FIRST  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_SECOND = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PRIME,
      ST_WALK,
      ST_DIV,
      ST_OUT
   } state_type;

   // merge engine -> divider handoff
   typedef struct packed {
      logic [SUM_W-1:0]   num;
      logic [SUM_W-1:0]   den;
      logic [SHARE_W-1:0] shared;
      logic               dropped;
   } sums_type;
endpackage
`default_nettype wire

[hdl/wmds_divider.sv]
// Restoring divider: floor((den-num)*2^16/den), one quotient bit per cycle.
// Depends on wmds_pkg.
`default_nettype none
module wmds_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire wmds_pkg::sums_type          sums,
   output logic                             done,
   output logic [wmds_pkg::SIM_W-1:0]       quotient,
   output logic                             zero_den
);
   import wmds_pkg::*;

   localparam int QB = 17;  // result never exceeds 2^16
   logic [SUM_W:0]   rem_ff, rem_in;
   logic [SUM_W-1:0] den_ff, den_in;
   logic [QB-1:0]    q_ff, q_in;
   logic [SUM_W+16:0] dvd_ff, dvd_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [SUM_W:0]   trial;
   logic [SUM_W+1:0] sub;
   logic [SUM_W-1:0] diff;

   assign diff = sums.den - sums.num;

   // num <= den, so the quotient fits in QB bits and the upper dividend bits
   // give only zeros: the remainder starts as those bits, (den-num)>>1, and
   // the last QB dividend bits are walked one per cycle
   always_comb begin
      rem_in = rem_ff; den_in = den_ff; q_in = q_ff; dvd_in = dvd_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff[SUM_W-1:0], dvd_ff[SUM_W+16]};
      sub = {1'b0, trial} - {2'b00, den_ff};
      if (start) begin
         busy_in = (sums.den != '0);
         den_in = sums.den;
         dvd_in = {diff[0], {(SUM_W+16){1'b0}}};
         rem_in = {2'b00, diff[SUM_W-1:1]};
         q_in = '0;
         cnt_in = 5'(QB - 1);
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[SUM_W+15:0], 1'b0};
         if (!sub[SUM_W+1]) begin
            rem_in = sub[SUM_W:0];
            q_in = {q_ff[QB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[QB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) busy_in = 1'b0;
      end
   end

   // QB steps, counted down to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; den_ff <= den_in; q_ff <= q_in; dvd_ff <= dvd_in;
   end

   logic busy_d_ff;
   always_ff @(posedge clock) begin
      if (reset) busy_d_ff <= 1'b0;
      else busy_d_ff <= busy_ff | start;
   end
   assign done = busy_d_ff & ~busy_ff & ~start;
   assign quotient = q_ff;
   assign zero_den = (den_ff == '0);
endmodule
`default_nettype wire

[hdl/weighted_multiset_distance_similarity_unit.sv]
// Top level: list memories, load/merge sequencer, weighting and output register.
// Depends on wmds_pkg, wmds_divider and the assertion macro header.
//
// Channel   Direction  Handshake         Payload
// req       in         req_valid/stall   set, label, has, last
// rsp       out        rsp_valid/stall   similarity, shared, flags
// csr       in         csr_write_enable  depth_first / depth_second
//
// Loading: one transaction per cycle, one label written per cycle.
// Closing transaction starts the merge: a prime state, then a walk over the stored
// labels run by run (a finished run may wait on the other list).
// Divide: 17 quotient steps, then done is flagged and the unit reopens for loading.
// A result still waiting in the rsp register holds a finished merge off the divider.
// Reset (synchronous) clears fills, closed bits, flags; memories need none.
// req_stall is high from the closing transaction through ST_OUT, after the result is registered.
`default_nettype none
module weighted_multiset_distance_similarity_unit #(
   parameter int LIST_DEPTH = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_set_select,
   input  wire logic [31:0] req_core_label,
   input  wire logic        req_has_label,
   input  wire logic        req_last_of_set,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [16:0]      rsp_similarity_q16,
   output logic [12:0]      rsp_shared_count,
   output logic             rsp_zero_weight,
   output logic             rsp_capacity_overflow,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data
);
   import wmds_pkg::*;
   `include "weighted_multiset_distance_similarity_unit_assert.svh"

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int FW = AW + 1;

   logic [LABEL_W-1:0] mem_a [LIST_DEPTH];
   logic [LABEL_W-1:0] mem_b [LIST_DEPTH];

   state_type st_ff, st_in;
   logic [FW-1:0] fa_ff, fa_in, fb_ff, fb_in;
   logic ca_ff, ca_in, cb_ff, cb_in, drop_ff, drop_in;
   logic [DEPTH_W-1:0] d1_ff, d2_ff;
   logic [FW-1:0] ia_ff, ia_in, ib_ff, ib_in;     // next read index
   logic [LABEL_W-1:0] ha_ff, ha_in, hb_ff, hb_in; // current run heads
   logic [FW-1:0] na_ff, na_in, nb_ff, nb_in;     // run counts
   logic va_ff, va_in, vb_ff, vb_in;               // run head valid
   logic [LABEL_W-1:0] rda_ff, rdb_ff;
   logic [FW-1:0] rd_addr_a, rd_addr_b;
   logic rd_ok_ff, rd_ok_in; // read data of previous cycle is fresh
   sums_type sums_ff, sums_in;
   logic div_start, div_done, div_zero;
   logic [SIM_W-1:0] div_q;
   logic rv_ff, rv_in;
   logic [SIM_W-1:0] rsim_ff;
   logic [SHARE_W-1:0] rsh_ff;
   logic rz_ff, rov_ff;

   logic acc, wr_a, wr_b, can_a, can_b;
   logic [LABEL_W-1:0] nxa, nxb;
   logic ea, eb;       // element available this cycle in each list
   logic ma, mb;       // element extends current run
   logic [FW-1:0] c1, c2;
   logic [FW+DEPTH_W-1:0] w1, w2;
   logic [SUM_W-1:0] addn, addd;
   logic [SHARE_W:0] sh_add, sh_sum;
   logic emit_a, emit_b;

   assign req_stall = (st_ff != ST_LOAD);
   assign acc = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= 16'd256; d2_ff <= 16'd256;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEPTH_FIRST:  d1_ff <= csr_write_data;
            CSR_DEPTH_SECOND: d2_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign can_a = ~req_set_select & ~ca_ff;
   assign can_b = req_set_select & ~cb_ff;
   assign wr_a = acc & can_a & req_has_label & (fa_ff < FW'(LIST_DEPTH));
   assign wr_b = acc & can_b & req_has_label & (fb_ff < FW'(LIST_DEPTH));

   // read one behind the next index
   assign rd_addr_a = ia_in - FW'(1);
   assign rd_addr_b = ib_in - FW'(1);

   always_ff @(posedge clock) begin
      if (wr_a) mem_a[fa_ff[AW-1:0]] <= req_core_label;
      if (wr_b) mem_b[fb_ff[AW-1:0]] <= req_core_label;
      rda_ff <= mem_a[rd_addr_a[AW-1:0]];
      rdb_ff <= mem_b[rd_addr_b[AW-1:0]];
   end

   // element at ia_ff-1 arrives in rda_ff; ea says it is a real element
   assign nxa = rda_ff;
   assign nxb = rdb_ff;
   assign ea = rd_ok_ff & (ia_ff <= fa_ff) & (ia_ff != '0);
   assign eb = rd_ok_ff & (ib_ff <= fb_ff) & (ib_ff != '0);
   assign ma = ea & (~va_ff | nxa == ha_ff);
   assign mb = eb & (~vb_ff | nxb == hb_ff);

   // a run is complete when its head is valid and no more elements extend it
   logic ra, rb, take_a, take_b, both;
   assign ra = va_ff & ~ma & (ea | ia_ff > fa_ff);
   assign rb = vb_ff & ~mb & (eb | ib_ff > fb_ff);
   // decide on complete runs; wait if a head still grows
   always_comb begin
      take_a = 1'b0; take_b = 1'b0;
      if (ra && rb) begin
         if (ha_ff == hb_ff) begin take_a = 1'b1; take_b = 1'b1; end
         else if (ha_ff < hb_ff) take_a = 1'b1;
         else take_b = 1'b1;
      end else if (ra && !vb_ff && ib_ff > fb_ff) take_a = 1'b1;
      else if (rb && !va_ff && ia_ff > fa_ff) take_b = 1'b1;
   end
   assign both = take_a & take_b;
   assign c1 = na_ff;
   assign c2 = nb_ff;
   assign w1 = take_a ? FW'(c1) * d2_ff : '0;
   assign w2 = take_b ? FW'(c2) * d1_ff : '0;
   always_comb begin
      addd = SUM_W'(w1) + SUM_W'(w2);
      addn = (w1 > w2) ? SUM_W'(w1 - w2) : SUM_W'(w2 - w1);
      sh_add = both ? ((c1 < c2) ? (SHARE_W+1)'(c1) : (SHARE_W+1)'(c2)) : '0;
      sh_sum = {1'b0, sums_ff.shared} + sh_add;
   end
   // reading advances when run head is not blocked
   assign emit_a = ~va_ff | ma | take_a;
   assign emit_b = ~vb_ff | mb | take_b;

   // the divide starts only once the rsp register is free
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_LOAD:  if (acc && ((can_a && req_last_of_set && cb_ff) ||
                                (can_b && req_last_of_set && ca_ff))) st_in = ST_PRIME;
         ST_PRIME: st_in = ST_WALK;
         ST_WALK:  if (!va_ff && !vb_ff && ia_ff > fa_ff && ib_ff > fb_ff && !rv_ff)
                      st_in = ST_DIV;
         ST_DIV:   if (div_done) st_in = ST_OUT;
         ST_OUT:   st_in = ST_LOAD;
         default:  st_in = ST_LOAD;
      endcase
   end

   always_comb begin
      fa_in = fa_ff; fb_in = fb_ff; ca_in = ca_ff; cb_in = cb_ff; drop_in = drop_ff;
      ia_in = ia_ff; ib_in = ib_ff; ha_in = ha_ff; hb_in = hb_ff;
      na_in = na_ff; nb_in = nb_ff; va_in = va_ff; vb_in = vb_ff;
      rd_ok_in = 1'b0; sums_in = sums_ff; div_start = 1'b0;
      case (st_ff)
         ST_LOAD: begin
            if (wr_a) fa_in = fa_ff + 1'b1;
            if (wr_b) fb_in = fb_ff + 1'b1;
            if (acc && (can_a || can_b) && req_has_label && !wr_a && !wr_b)
               drop_in = 1'b1;
            if (acc && can_a && req_last_of_set) ca_in = 1'b1;
            if (acc && can_b && req_last_of_set) cb_in = 1'b1;
            ia_in = '0; ib_in = '0;
            va_in = 1'b0; vb_in = 1'b0;
            sums_in = '0;
            sums_in.dropped = drop_in;
         end
         ST_PRIME: begin
            ia_in = FW'(1); ib_in = FW'(1); rd_ok_in = 1'b1;
         end
         ST_WALK: begin
            rd_ok_in = 1'b1;
            sums_in.num = sums_ff.num + addn;
            sums_in.den = sums_ff.den + addd;
            sums_in.shared = sh_sum[SHARE_W] ? '1 : sh_sum[SHARE_W-1:0];
            if (take_a) begin va_in = 1'b0; na_in = '0; end
            if (take_b) begin vb_in = 1'b0; nb_in = '0; end
            if (ma) begin
               va_in = 1'b1; ha_in = nxa; na_in = na_ff + 1'b1;
            end else if (take_a && ea) begin
               va_in = 1'b1; ha_in = nxa; na_in = FW'(1);
            end
            if (mb) begin
               vb_in = 1'b1; hb_in = nxb; nb_in = nb_ff + 1'b1;
            end else if (take_b && eb) begin
               vb_in = 1'b1; hb_in = nxb; nb_in = FW'(1);
            end
            if (!va_ff && !ea) na_in = '0;
            if (!vb_ff && !eb) nb_in = '0;
            if ((emit_a && ea) || (ia_ff > fa_ff)) ia_in = (ia_ff > fa_ff) ? ia_ff : ia_ff + 1'b1;
            if ((emit_b && eb) || (ib_ff > fb_ff)) ib_in = (ib_ff > fb_ff) ? ib_ff : ib_ff + 1'b1;
            if (st_in == ST_DIV) div_start = 1'b1;
         end
         ST_OUT: begin
            fa_in = '0; fb_in = '0; ca_in = 1'b0; cb_in = 1'b0; drop_in = 1'b0;
         end
         default: ;
      endcase
   end

   // output register: loaded at divide end, held while stalled
   always_comb begin
      rv_in = rv_ff;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      if (st_ff == ST_DIV && div_done) rv_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD; fa_ff <= '0; fb_ff <= '0; ca_ff <= 1'b0; cb_ff <= 1'b0;
         drop_ff <= 1'b0; va_ff <= 1'b0; vb_ff <= 1'b0; rd_ok_ff <= 1'b0;
         rv_ff <= 1'b0; ia_ff <= '0; ib_ff <= '0; na_ff <= '0; nb_ff <= '0;
      end else begin
         st_ff <= st_in; fa_ff <= fa_in; fb_ff <= fb_in; ca_ff <= ca_in; cb_ff <= cb_in;
         drop_ff <= drop_in; va_ff <= va_in; vb_ff <= vb_in; rd_ok_ff <= rd_ok_in;
         rv_ff <= rv_in; ia_ff <= ia_in; ib_ff <= ib_in; na_ff <= na_in; nb_ff <= nb_in;
      end
      ha_ff <= ha_in; hb_ff <= hb_in; sums_ff <= sums_in;
      if (st_ff == ST_DIV && div_done) begin
         rsim_ff <= div_zero ? '0 : div_q;
         rsh_ff <= sums_ff.shared;
         rz_ff <= div_zero;
         rov_ff <= sums_ff.dropped;
      end
   end

   wmds_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .sums(sums_in),
      .done(div_done), .quotient(div_q), .zero_den(div_zero)
   );

   assign rsp_valid = rv_ff;
   assign rsp_similarity_q16 = rsim_ff;
   assign rsp_shared_count = rsh_ff;
   assign rsp_zero_weight = rz_ff;
   assign rsp_capacity_overflow = rov_ff;

   `WMDS_ASSERT_IMP(a_fill_a, clock, reset, 1'b1, fa_ff <= FW'(LIST_DEPTH), "fill A over depth")
   `WMDS_ASSERT_IMP(a_fill_b, clock, reset, 1'b1, fb_ff <= FW'(LIST_DEPTH), "fill B over depth")
   `WMDS_ASSERT_IMP(a_no_result_in_div, clock, reset, rv_ff, st_ff != ST_DIV, "result in DIV")
   `WMDS_ASSERT_NXT(a_zero_sim, clock, reset, st_ff == ST_DIV && div_done && div_zero, rsp_similarity_q16 == '0, "zero den sim")
endmodule
`default_nettype wire

[test/weighted_multiset_distance_similarity_unit_test.sv]
// Testbench for weighted_multiset_distance_similarity_unit: directed and random list pairs,
// checked against a behavioral scoring model. Depends on wmds_pkg and the unit's RTL.
`timescale 1ns / 100ps
`default_nettype none
module weighted_multiset_distance_similarity_unit_test;
   import wmds_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int STALL_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_set_select = 1'b0;
   logic [31:0] req_core_label = '0;
   logic        req_has_label = 1'b0;
   logic        req_last_of_set = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [16:0] rsp_similarity_q16;
   logic [12:0] rsp_shared_count;
   logic        rsp_zero_weight;
   logic        rsp_capacity_overflow;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_DEPTH_FIRST;
   logic [15:0] csr_write_data = '0;

   weighted_multiset_distance_similarity_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      logic [SIM_W-1:0]   sim;
      logic [SHARE_W-1:0] shared;
      logic               zero_w;
      logic               overflow;
   } score_type;

   // shadow copy of the unit's state
   logic [31:0]   stored_labels[2][$];
   bit            list_closed[2];
   bit            labels_dropped;
   logic [15:0]   weight_first = 16'd256;
   logic [15:0]   weight_second = 16'd256;

   score_type     pending_scores[$];
   int            error_count = 0;
   int            items_sent = 0;
   int            quiet_cycles = 0;
   bit            idling_on = 1'b1;

   // length of the run of equal labels starting at p
   function automatic int run_len(int side, int p);
      int q;
      q = p + 1;
      while (q < stored_labels[side].size() && stored_labels[side][q] == stored_labels[side][p])
         q++;
      return q - p;
   endfunction

   function automatic score_type score_pair();
      score_type r;
      int i, j, n1, n2, c1, c2;
      longint unsigned num, den, shr, w1, w2;
      i = 0; j = 0; num = 0; den = 0; shr = 0;
      n1 = stored_labels[0].size();
      n2 = stored_labels[1].size();
      while (i < n1 || j < n2) begin
         if (i < n1 && j < n2 && stored_labels[0][i] == stored_labels[1][j]) begin
            c1 = run_len(0, i);
            c2 = run_len(1, j);
            w1 = longint'(c1) * weight_second;
            w2 = longint'(c2) * weight_first;
            num += (w1 > w2) ? w1 - w2 : w2 - w1;
            den += w1 + w2;
            shr += (c1 < c2) ? c1 : c2;
            i += c1;
            j += c2;
         end else if (j >= n2 || (i < n1 && stored_labels[0][i] < stored_labels[1][j])) begin
            c1 = run_len(0, i);
            w1 = longint'(c1) * weight_second;
            num += w1;
            den += w1;
            i += c1;
         end else begin
            c2 = run_len(1, j);
            w2 = longint'(c2) * weight_first;
            num += w2;
            den += w2;
            j += c2;
         end
      end
      r.sim      = (den != 0) ? SIM_W'(((den - num) << 16) / den) : '0;
      r.shared   = (shr > 8191) ? 13'd8191 : SHARE_W'(shr);
      r.zero_w   = (den == 0);
      r.overflow = labels_dropped;
      return r;
   endfunction

   // update shadow state for one accepted transaction
   task automatic track_item(bit sel, logic [31:0] label, bit has, bit last);
      if (list_closed[sel]) return;
      if (has) begin
         if (stored_labels[sel].size() < STORE_DEPTH)
            stored_labels[sel].insert(stored_labels[sel].size(), label);
         else labels_dropped = 1'b1;
      end
      if (last) list_closed[sel] = 1'b1;
      if (list_closed[0] && list_closed[1]) begin
         pending_scores.insert(pending_scores.size(), score_pair());
         stored_labels[0].delete();
         stored_labels[1].delete();
         list_closed[0] = 1'b0;
         list_closed[1] = 1'b0;
         labels_dropped = 1'b0;
      end
   endtask

   // one request transaction; called at a rising edge
   task automatic send_item(bit sel, logic [31:0] label, bit has, bit last);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_set_select  <= sel;
      req_core_label  <= label;
      req_has_label   <= has;
      req_last_of_set <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_item(sel, label, has, last);
      items_sent++;
   endtask

   // registers change only with no pair in flight
   task automatic write_weight(logic idx, logic [15:0] value);
      req_valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DEPTH_FIRST) weight_first = value;
      else weight_second = value;
   endtask

   // send two lists interleaved; noise, separate closes and writes to closed lists mixed in
   task automatic send_pair(logic [31:0] a[$], logic [31:0] b[$], bit noisy);
      int  ptr[2];
      bit  done[2];
      bit  side;
      logic [31:0] lists[2][$];
      lists[0] = a; lists[1] = b;
      ptr[0] = 0; ptr[1] = 0; done[0] = 0; done[1] = 0;
      while (!(done[0] && done[1])) begin
         side = done[0] ? 1'b1 : done[1] ? 1'b0 : 1'($urandom_range(0, 1));
         if (noisy && $urandom_range(0, 9) == 0) begin
            // no label and not last: no effect; to a closed list: ignored
            send_item(side ^ (done[0] ^ done[1] ? 1'b0 : 1'b0), $urandom, 1'b0, 1'b0);
            if (done[0] != done[1] && $urandom_range(0, 1))
               send_item(done[1], $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
         end else if (ptr[side] < lists[side].size()) begin
            if (ptr[side] == lists[side].size() - 1 && $urandom_range(0, 1)) begin
               send_item(side, lists[side][ptr[side]], 1'b1, 1'b1);
               done[side] = 1'b1;
            end else begin
               send_item(side, lists[side][ptr[side]], 1'b1, 1'b0);
            end
            ptr[side]++;
         end else begin
            send_item(side, $urandom, 1'b0, 1'b1);
            done[side] = 1'b1;
         end
      end
   endtask

   // sorted multiset drawn from a shared pool so labels overlap between lists
   function automatic void make_list(ref logic [31:0] pool[$], input int n,
                                     output logic [31:0] q[$]);
      int k;
      q.delete();
      k = 0;
      for (int m = 0; m < n; m++) begin
         k += $urandom_range(0, 1) ? 0 : $urandom_range(0, 2);
         if (k >= pool.size()) k = pool.size() - 1;
         q.insert(q.size(), pool[k]);
      end
   endfunction

   task automatic random_pair(int max_n, bit unsorted);
      logic [31:0] pool[$], a[$], b[$];
      int psize;
      psize = $urandom_range(1, 12);
      for (int m = 0; m < psize; m++) pool.insert(pool.size(), $urandom);
      pool.sort();
      make_list(pool, $urandom_range(0, max_n), a);
      make_list(pool, $urandom_range(0, max_n), b);
      if (unsorted) begin
         a.shuffle();
         b.shuffle();
      end
      send_pair(a, b, 1'b1);
   endtask

   // ---------------- tests ----------------
   task automatic test_default_weights();
      send_pair('{32'd5, 32'd5, 32'd7, 32'd9}, '{32'd5, 32'd7, 32'd7, 32'd10}, 1'b0);
      send_pair('{32'd1, 32'd2}, '{32'd1, 32'd2}, 1'b0);
   endtask

   task automatic test_empty_lists();
      send_pair('{}, '{}, 1'b0);
      send_pair('{32'd3}, '{}, 1'b0);
   endtask

   task automatic test_label_extremes();
      send_pair('{32'h0, 32'hFFFF_FFFF}, '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0);
      send_pair('{32'h5555_5555}, '{32'hAAAA_AAAA}, 1'b0);
   endtask

   task automatic test_closed_and_noise();
      send_item(1'b0, 32'd4, 1'b1, 1'b1);
      send_item(1'b0, 32'd8, 1'b1, 1'b0);   // first list closed: ignored
      send_item(1'b0, 32'd8, 1'b0, 1'b1);
      send_item(1'b1, 32'd2, 1'b0, 1'b0);   // no label, no close
      send_item(1'b1, 32'd4, 1'b1, 1'b1);
   endtask

   task automatic test_weight_extremes();
      write_weight(CSR_DEPTH_FIRST, 16'd0);
      write_weight(CSR_DEPTH_SECOND, 16'd0);
      send_pair('{32'd1, 32'd2}, '{32'd2}, 1'b0);   // all weights zero
      write_weight(CSR_DEPTH_SECOND, 16'hFFFF);
      send_pair('{32'd1, 32'd2}, '{32'd2, 32'd2}, 1'b0);
      write_weight(CSR_DEPTH_FIRST, 16'hFFFF);
      send_pair('{32'd1, 32'd2, 32'd2}, '{32'd2, 32'd3}, 1'b0);
      write_weight(CSR_DEPTH_FIRST, 16'h0180);
      write_weight(CSR_DEPTH_SECOND, 16'h00C0);
      send_pair('{32'd6, 32'd6, 32'd6}, '{32'd6}, 1'b0);
   endtask

   task automatic test_unsorted();
      send_pair('{32'd9, 32'd3, 32'd3, 32'd7}, '{32'd7, 32'd3, 32'd9}, 1'b0);
   endtask

   task automatic test_store_full();
      logic [31:0] big[$], small_list[$];
      for (int m = 0; m < STORE_DEPTH + 3; m++) big.insert(big.size(), 32'(m / 3));
      small_list = '{32'd0, 32'd1, 32'd1, 32'd5000};
      send_pair(big, small_list, 1'b0);
   endtask

   task automatic test_random();
      int stop_at;
      stop_at = items_sent + 1500;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 40) == 0)
            write_weight(1'($urandom_range(0, 1)), 16'($urandom));
         if (items_sent > stop_at - 200) idling_on = 1'b0;
         random_pair($urandom_range(0, 7) == 0 ? 60 : 12, $urandom_range(0, 15) == 0);
      end
   endtask

   // receiver stall bursts
   int rsp_burst = 0;
   always @(posedge clock) begin
      if (rsp_burst > 0) begin
         rsp_burst <= rsp_burst - 1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         rsp_burst <= $urandom_range(1, 4) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      score_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scores.size() == 0) begin
            $display("%0t: unexpected result sim=%0d shared=%0d", $time,
                     rsp_similarity_q16, rsp_shared_count);
            error_count++;
         end else begin
            want = pending_scores.pop_front();
            if (rsp_similarity_q16 !== want.sim) begin
               $display("%0t: similarity expected %0d actual %0d", $time, want.sim,
                        rsp_similarity_q16);
               error_count++;
            end
            if (rsp_shared_count !== want.shared) begin
               $display("%0t: shared_count expected %0d actual %0d", $time, want.shared,
                        rsp_shared_count);
               error_count++;
            end
            if (rsp_zero_weight !== want.zero_w) begin
               $display("%0t: zero_weight expected %0d actual %0d", $time, want.zero_w,
                        rsp_zero_weight);
               error_count++;
            end
            if (rsp_capacity_overflow !== want.overflow) begin
               $display("%0t: capacity_overflow expected %0d actual %0d", $time,
                        want.overflow, rsp_capacity_overflow);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_weights();
      test_empty_lists();
      test_label_extremes();
      test_closed_and_noise();
      test_unsorted();
      test_weight_extremes();
      test_store_full();
      test_random();
      req_valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_scores.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/wmds_pkg.sv
hdl/wmds_divider.sv
hdl/weighted_multiset_distance_similarity_unit.sv
test/weighted_multiset_distance_similarity_unit_test.sv
